@@ sv/ipk_pkg.sv @@
`timescale 1ns / 1ps

package ipk_pkg;

    localparam int unsigned DOT_LEN_W = 8;
    localparam int unsigned TIMER_W   = 10;
    localparam int unsigned SPEED_W   = 6;

    localparam logic [TIMER_W-1:0]   TIMER_MAX     = {TIMER_W{1'b1}};
    localparam logic [DOT_LEN_W-1:0] DOT_LEN_RESET = 8'd80;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DOT_ON   = 3'd1,
        PH_DOT_GAP  = 3'd2,
        PH_DASH_ON  = 3'd3,
        PH_DASH_GAP = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLOSED = 2'd1,
        EV_OPENED = 2'd2
    } t_event;

    typedef struct packed {
        t_phase               phase;
        logic [TIMER_W-1:0]   remaining;
        t_event               dot_pend;
        t_event               dash_pend;
        logic                 key;
    } t_state;

    // dot length in units for each speed code, slow codes clamped to 5 wpm
    localparam logic [DOT_LEN_W-1:0] DOT_LEN_TABLE [0:63] = '{
        8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd200, 8'd171,
        8'd150, 8'd133, 8'd120, 8'd109, 8'd100, 8'd92,  8'd85,  8'd80,
        8'd75,  8'd70,  8'd66,  8'd63,  8'd60,  8'd57,  8'd54,  8'd52,
        8'd50,  8'd48,  8'd46,  8'd44,  8'd42,  8'd41,  8'd40,  8'd38,
        8'd37,  8'd36,  8'd35,  8'd34,  8'd33,  8'd32,  8'd31,  8'd30,
        8'd30,  8'd29,  8'd28,  8'd27,  8'd27,  8'd26,  8'd26,  8'd25,
        8'd25,  8'd24,  8'd24,  8'd23,  8'd23,  8'd22,  8'd22,  8'd21,
        8'd21,  8'd21,  8'd20,  8'd20,  8'd20,  8'd19,  8'd19,  8'd19
    };

endpackage

@@ sv/iambic_paddle_keyer.sv @@
`timescale 1ns / 1ps
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------------
// in       | i_in_valid / o_in_ready    | i_tick i_dot_event i_dash_event
//          |                            | i_dot_closed i_dash_closed
// out      | o_out_valid / i_out_ready  | o_key_down o_keyer_phase
// cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_speed_wpm
//
// One word per cycle: the keyer state advances in the cycle the word is accepted
// and the result sits in the output register from the following cycle.
// A full output register that is taken in the same cycle still admits a new word;
// a stalled output holds and stops input acceptance. cfg is always ready.
// Synchronous active-low reset: idle, key up, no pending events, 15 wpm.

module iambic_paddle_keyer
    import ipk_pkg::*;
#(
    parameter int unsigned DASH_WEIGHT = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_tick,
    input  logic [1:0]         i_dot_event,
    input  logic [1:0]         i_dash_event,
    input  logic               i_dot_closed,
    input  logic               i_dash_closed,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_key_down,
    output logic [2:0]         o_keyer_phase,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SPEED_W-1:0] i_cfg_speed_wpm
);

    t_state               r_state;
    t_state               n_state;
    logic [DOT_LEN_W-1:0] r_dot_length;
    logic                 r_out_valid;
    logic                 r_key_down;
    t_phase               r_phase;
    logic                 in_accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;

    ipk_step #(
        .DASH_WEIGHT (DASH_WEIGHT)
    ) u_step (
        .i_state       (r_state),
        .i_dot_length  (r_dot_length),
        .i_tick        (i_tick),
        .i_dot_event   (i_dot_event),
        .i_dash_event  (i_dash_event),
        .i_dot_closed  (i_dot_closed),
        .i_dash_closed (i_dash_closed),
        .o_state       (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '{phase: PH_IDLE, remaining: '0, dot_pend: EV_NONE,
                              dash_pend: EV_NONE, key: 1'b0};
            r_dot_length <= DOT_LEN_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dot_length <= DOT_LEN_TABLE[i_cfg_speed_wpm];
            end
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_key_down <= n_state.key;
            r_phase    <= n_state.phase;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_down    = r_key_down;
    assign o_keyer_phase = r_phase;

`ifndef SYNTHESIS
    a_key_only_when_on : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.key |-> (r_state.phase == PH_DOT_ON || r_state.phase == PH_DASH_ON))
        else $error("key down outside an element");

    a_idle_no_pending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_IDLE |->
            (r_state.dot_pend == EV_NONE && r_state.dash_pend == EV_NONE))
        else $error("pending event left while idle");

    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (o_out_valid && o_key_down == $past(n_state.key)))
        else $error("accepted word produced no result");
`endif

endmodule

@@ sv/ipk_step.sv @@
`timescale 1ns / 1ps

module ipk_step
    import ipk_pkg::*;
#(
    parameter int unsigned DASH_WEIGHT = 3
) (
    input  t_state                 i_state,
    input  logic [DOT_LEN_W-1:0]   i_dot_length,
    input  logic                   i_tick,
    input  logic [1:0]             i_dot_event,
    input  logic [1:0]             i_dash_event,
    input  logic                   i_dot_closed,
    input  logic                   i_dash_closed,
    output t_state                 o_state
);

    localparam int unsigned PROD_W = DOT_LEN_W + $clog2(DASH_WEIGHT + 1);

    logic [PROD_W-1:0]  dash_prod;
    logic [TIMER_W-1:0] dot_load;
    logic [TIMER_W-1:0] dash_load;

    assign dash_prod = PROD_W'(i_dot_length) * PROD_W'(DASH_WEIGHT);
    assign dot_load  = TIMER_W'(i_dot_length);
    assign dash_load = (dash_prod > PROD_W'(TIMER_MAX)) ? TIMER_MAX : TIMER_W'(dash_prod);

    always_comb begin
        t_state             s;
        logic [TIMER_W-1:0] rem_dec;
        logic               go_dot;

        s = i_state;
        if (i_dot_event == EV_CLOSED || i_dot_event == EV_OPENED) begin
            s.dot_pend = t_event'(i_dot_event);
        end
        if (i_dash_event == EV_CLOSED || i_dash_event == EV_OPENED) begin
            s.dash_pend = t_event'(i_dash_event);
        end
        rem_dec = (s.remaining != '0) ? s.remaining - 1'b1 : '0;
        go_dot  = 1'b0;

        unique case (s.phase)
            PH_IDLE: begin
                priority if (s.dot_pend != EV_NONE) begin
                    if (s.dot_pend == EV_CLOSED) begin
                        s.phase     = PH_DOT_ON;
                        s.key       = 1'b1;
                        s.remaining = dot_load;
                    end else begin
                        s.key = 1'b0;
                    end
                    s.dot_pend  = EV_NONE;
                    s.dash_pend = EV_NONE;
                end else if (s.dash_pend != EV_NONE) begin
                    if (s.dash_pend == EV_CLOSED) begin
                        s.phase     = PH_DASH_ON;
                        s.key       = 1'b1;
                        s.remaining = dash_load;
                    end else begin
                        s.key = 1'b0;
                    end
                    s.dash_pend = EV_NONE;
                end else begin
                    // nothing pending: hold
                end
            end
            PH_DOT_ON, PH_DOT_GAP, PH_DASH_ON, PH_DASH_GAP: begin
                if (i_tick) begin
                    s.remaining = rem_dec;
                    if (rem_dec == '0) begin
                        unique case (s.phase)
                            PH_DOT_ON: begin
                                s.phase     = PH_DOT_GAP;
                                s.key       = 1'b0;
                                s.remaining = dot_load;
                            end
                            PH_DASH_ON: begin
                                s.phase     = PH_DASH_GAP;
                                s.key       = 1'b0;
                                s.remaining = dot_load;
                            end
                            default: begin
                                // gap over: repeat, alternate or drop to idle
                                if (!i_dot_closed && !i_dash_closed) begin
                                    s.phase     = PH_IDLE;
                                    s.dot_pend  = EV_NONE;
                                    s.dash_pend = EV_NONE;
                                end else begin
                                    if (s.phase == PH_DOT_GAP) begin
                                        go_dot = i_dot_closed && !i_dash_closed;
                                    end else begin
                                        go_dot = i_dot_closed;
                                    end
                                    s.key = 1'b1;
                                    if (go_dot) begin
                                        s.phase     = PH_DOT_ON;
                                        s.remaining = dot_load;
                                    end else begin
                                        s.phase     = PH_DASH_ON;
                                        s.remaining = dash_load;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            default: begin
                s.phase     = PH_IDLE;
                s.key       = 1'b0;
                s.dot_pend  = EV_NONE;
                s.dash_pend = EV_NONE;
            end
        endcase

        o_state = s;
    end

endmodule

@@ tb/keyer_checker.sv @@
`timescale 1ns / 1ps

module keyer_checker
    import ipk_pkg::*;
#(
    parameter int unsigned DASH_WEIGHT = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_tick,
    input  logic [1:0]         i_dot_event,
    input  logic [1:0]         i_dash_event,
    input  logic               i_dot_closed,
    input  logic               i_dash_closed,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_key_down,
    input  logic [2:0]         i_keyer_phase,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [SPEED_W-1:0] i_cfg_speed_wpm,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int unsigned UNITS_PER_MINUTE = 1200;
    localparam int unsigned SLOWEST_WPM      = 5;
    localparam int          PRINT_CAP        = 100;

    typedef struct packed {
        logic   key;
        t_phase phase;
    } t_keying;

    t_phase               ph;
    logic [TIMER_W-1:0]   remain;
    t_event               dot_pend;
    t_event               dash_pend;
    logic                 key;
    logic [DOT_LEN_W-1:0] dot_len;
    t_keying              expected_keying [$];
    int                   errors = 0;

    function automatic logic [TIMER_W-1:0] timer_load(input int unsigned units);
        return (units > TIMER_MAX) ? TIMER_MAX : units[TIMER_W-1:0];
    endfunction

    function void start_element(input t_phase on_phase);
        ph  = on_phase;
        key = 1'b1;
        if (on_phase == PH_DASH_ON) begin
            remain = timer_load(dot_len * DASH_WEIGHT);
        end else begin
            remain = timer_load(dot_len);
        end
    endfunction

    function void start_gap(input t_phase gap_phase);
        ph     = gap_phase;
        key    = 1'b0;
        remain = timer_load(dot_len);
    endfunction

    function void go_idle();
        ph        = PH_IDLE;
        dot_pend  = EV_NONE;
        dash_pend = EV_NONE;
    endfunction

    function t_keying predict_keying(input logic tick, input logic [1:0] dev,
                                     input logic [1:0] hev, input logic dot_lv,
                                     input logic dash_lv);
        t_keying res;
        if (dev == EV_CLOSED || dev == EV_OPENED) dot_pend = t_event'(dev);
        if (hev == EV_CLOSED || hev == EV_OPENED) dash_pend = t_event'(hev);
        case (ph)
            PH_IDLE: begin
                if (dot_pend != EV_NONE) begin
                    if (dot_pend == EV_CLOSED) start_element(PH_DOT_ON);
                    else key = 1'b0;
                    dot_pend  = EV_NONE;
                    dash_pend = EV_NONE;
                end else if (dash_pend != EV_NONE) begin
                    if (dash_pend == EV_CLOSED) start_element(PH_DASH_ON);
                    else key = 1'b0;
                    dash_pend = EV_NONE;
                end
            end
            PH_DOT_ON, PH_DOT_GAP, PH_DASH_ON, PH_DASH_GAP: begin
                if (tick) begin
                    if (remain != '0) remain = remain - 1'b1;
                    if (remain == '0) begin
                        case (ph)
                            PH_DOT_ON:  start_gap(PH_DOT_GAP);
                            PH_DASH_ON: start_gap(PH_DASH_GAP);
                            PH_DOT_GAP: begin
                                if (!dot_lv && !dash_lv) go_idle();
                                else if (dot_lv && !dash_lv) start_element(PH_DOT_ON);
                                else start_element(PH_DASH_ON);
                            end
                            default: begin
                                if (!dot_lv && !dash_lv) go_idle();
                                else if (!dot_lv && dash_lv) start_element(PH_DASH_ON);
                                else start_element(PH_DOT_ON);
                            end
                        endcase
                    end
                end
            end
            default: begin
                key = 1'b0;
                go_idle();
            end
        endcase
        res.key   = key;
        res.phase = ph;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PRINT_CAP) begin
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_keying head;
        if (!i_rst_n) begin
            ph        = PH_IDLE;
            remain    = '0;
            dot_pend  = EV_NONE;
            dash_pend = EV_NONE;
            key       = 1'b0;
            dot_len   = DOT_LEN_RESET;
            expected_keying.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_keying.size() == 0) begin
                    report_mismatch("word with nothing expected, key_down", i_key_down, 0);
                end else begin
                    head = expected_keying.pop_front();
                    if (i_key_down !== head.key) begin
                        report_mismatch("key_down", i_key_down, head.key);
                    end
                    if (i_keyer_phase !== head.phase) begin
                        report_mismatch("keyer_phase", i_keyer_phase, head.phase);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                dot_len = DOT_LEN_W'(UNITS_PER_MINUTE / ((i_cfg_speed_wpm < SLOWEST_WPM) ?
                                                         SLOWEST_WPM : i_cfg_speed_wpm));
            end
            if (i_in_valid && i_in_ready) begin
                expected_keying.push_back(predict_keying(i_tick, i_dot_event, i_dash_event,
                                                         i_dot_closed, i_dash_closed));
            end
        end
        o_pending    <= expected_keying.size();
        o_fail_count <= errors;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import ipk_pkg::*;

    localparam logic [1:0] EV_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 300;
    localparam int         PHASES      = 8;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_tick       = 1'b0;
    logic [1:0]         in_dot_event  = EV_NONE;
    logic [1:0]         in_dash_event = EV_NONE;
    logic               in_dot_closed = 1'b0;
    logic               in_dash_closed = 1'b0;
    logic               out_ready     = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic [SPEED_W-1:0] cfg_speed     = '0;
    logic               calm          = 1'b0;
    int                 idle_cycles   = 0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_key_down;
    logic [2:0]         o_keyer_phase;
    logic               o_cfg_ready;
    int                 fail_count;
    int                 pending;

    always #1 clk = ~clk;

    iambic_paddle_keyer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_tick          (in_tick),
        .i_dot_event     (in_dot_event),
        .i_dash_event    (in_dash_event),
        .i_dot_closed    (in_dot_closed),
        .i_dash_closed   (in_dash_closed),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_key_down      (o_key_down),
        .o_keyer_phase   (o_keyer_phase),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_speed_wpm (cfg_speed)
    );

    keyer_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (o_in_ready),
        .i_tick          (in_tick),
        .i_dot_event     (in_dot_event),
        .i_dash_event    (in_dash_event),
        .i_dot_closed    (in_dot_closed),
        .i_dash_closed   (in_dash_closed),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .i_key_down      (o_key_down),
        .i_keyer_phase   (o_keyer_phase),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_speed_wpm (cfg_speed),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    task automatic send_word(input logic tick, input logic [1:0] dev, input logic [1:0] hev,
                             input logic dot_lv, input logic dash_lv);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_tick        <= tick;
        in_dot_event   <= dev;
        in_dash_event  <= hev;
        in_dot_closed  <= dot_lv;
        in_dash_closed <= dash_lv;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
    endtask

    // drop valid and wait for every outstanding word
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial begin : sink
        int hold;
        @(posedge clk);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 6);
            if (hold != 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!o_out_valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [SPEED_W-1:0] plan [0:PHASES-1];
        logic               dot_lv;
        logic               dash_lv;
        logic               tick;
        logic [1:0]         dev;
        logic [1:0]         hev;
        logic               dl;
        logic               hl;
        int                 count;

        plan    = '{6'd15, 6'd63, 6'd0, 6'd60, 6'd20, 6'd5, 6'd47, 6'd0};
        plan[6] = SPEED_W'($urandom_range(21, 60));
        plan[7] = SPEED_W'($urandom_range(0, 63));
        dot_lv  = 1'b0;
        dash_lv = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(1'b1, EV_NONE,   EV_NONE,   1'b0, 1'b0);
        send_word(1'b0, EV_UNUSED, EV_UNUSED, 1'b1, 1'b1);
        send_word(1'b1, EV_OPENED, EV_NONE,   1'b0, 1'b0);
        send_word(1'b0, EV_NONE,   EV_OPENED, 1'b0, 1'b0);
        send_word(1'b0, EV_OPENED, EV_OPENED, 1'b0, 1'b0);
        send_word(1'b0, EV_NONE,   EV_NONE,   1'b0, 1'b0);
        send_word(1'b0, EV_CLOSED, EV_CLOSED, 1'b1, 1'b1);
        send_word(1'b1, EV_OPENED, EV_CLOSED, 1'b1, 1'b1);
        send_word(1'b1, EV_UNUSED, EV_OPENED, 1'b1, 1'b0);
        send_word(1'b0, EV_CLOSED, EV_UNUSED, 1'b0, 1'b1);
        send_word(1'b1, EV_NONE,   EV_NONE,   1'b1, 1'b1);
        send_word(1'b1, EV_NONE,   EV_NONE,   1'b0, 1'b0);
        settle();
        send_word(1'b0, EV_NONE,   EV_CLOSED, 1'b0, 1'b1);
        send_word(1'b1, EV_CLOSED, EV_NONE,   1'b1, 1'b1);
        send_word(1'b1, EV_NONE,   EV_OPENED, 1'b1, 1'b0);
        send_word(1'b0, EV_OPENED, EV_NONE,   1'b0, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                settle();
                cfg_valid <= 1'b1;
                cfg_speed <= plan[p];
                @(posedge clk);
                while (!o_cfg_ready) @(posedge clk);
                cfg_valid <= 1'b0;
            end
            count = (plan[p] >= 20) ? 250 : 80;
            for (int i = 0; i < count; i++) begin
                if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 7) == 0) begin
                    tick = 1'($urandom_range(0, 1));
                    dev  = 2'($urandom_range(0, 3));
                    hev  = 2'($urandom_range(0, 3));
                    dl   = 1'($urandom_range(0, 1));
                    hl   = 1'($urandom_range(0, 1));
                end else begin
                    tick = ($urandom_range(0, 7) != 0);
                    dev  = EV_NONE;
                    hev  = EV_NONE;
                    if ($urandom_range(0, 9) == 0) begin
                        dot_lv = !dot_lv;
                        dev    = dot_lv ? EV_CLOSED : EV_OPENED;
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        dash_lv = !dash_lv;
                        hev     = dash_lv ? EV_CLOSED : EV_OPENED;
                    end
                    dl = dot_lv;
                    hl = dash_lv;
                end
                send_word(tick, dev, hev, dl, hl);
            end
        end

        calm = 1'b0;
        settle();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
